// ----- rtl/mrsr_pkg.sv -----
`default_nettype none

package mrsr_pkg;

  localparam int DAYS_DEF   = 32;
  localparam int PEOPLE_DEF = 8;
  localparam int SLOTS_DEF  = 16;

  localparam int DAY_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int PART_W   = 8;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 16;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_CLR   = 4'd0;
  localparam step_t S_WAIT  = 4'd1;
  localparam step_t S_VALID = 4'd2;
  localparam step_t S_RD0   = 4'd3;
  localparam step_t S_CHK   = 4'd4;
  localparam step_t S_DEC   = 4'd5;
  localparam step_t S_WR    = 4'd6;
  localparam step_t S_OUT   = 4'd7;
  localparam step_t S_GO    = 4'd8;
  localparam step_t S_REJ   = 4'd9;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOT_CLR_LAST,
    C_NOT_IN_VALID,
    C_INVALID,
    C_NOT_P_LAST,
    C_CLASH,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic                clr_wr;
    logic                in_rdy;
    logic                rd_first;
    logic                chk;
    logic                wr;
    logic                p_clr;
    logic                st_we;
    logic [STATUS_W-1:0] st_val;
    logic                rej_inc;
    logic                out_ld;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic invalid;
    logic p_last;
    logic clash;
  } flags_t;

  typedef struct packed {
    step_t jmp;
    cond_e cond;
    ctrl_t act;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w      = '0;
    w.cond = C_ALWAYS;
    w.jmp  = S_WAIT;
    case (s)
      S_CLR: begin
        w.act.clr_wr = 1'b1;
        w.cond       = C_NOT_CLR_LAST;
        w.jmp        = S_CLR;
      end
      S_WAIT: begin
        w.act.in_rdy = 1'b1;
        w.act.p_clr  = 1'b1;
        w.cond       = C_NOT_IN_VALID;
        w.jmp        = S_WAIT;
      end
      S_VALID: begin
        w.act.st_we  = 1'b1;
        w.act.st_val = ST_RANGE;
        w.cond       = C_INVALID;
        w.jmp        = S_OUT;
      end
      S_RD0: begin
        w.act.rd_first = 1'b1;
        w.cond         = C_NOT_P_LAST;
        w.jmp          = S_CHK;
      end
      S_CHK: begin
        w.act.chk = 1'b1;
        w.cond    = C_NOT_P_LAST;
        w.jmp     = S_CHK;
      end
      S_DEC: begin
        w.act.p_clr = 1'b1;
        w.cond      = C_CLASH;
        w.jmp       = S_REJ;
      end
      S_WR: begin
        w.act.wr     = 1'b1;
        w.act.st_we  = 1'b1;
        w.act.st_val = ST_OK;
        w.cond       = C_NOT_P_LAST;
        w.jmp        = S_WR;
      end
      S_OUT: begin
        w.act.out_ld = 1'b1;
        w.cond       = C_OUT_BUSY;
        w.jmp        = S_OUT;
      end
      S_GO: begin
        w.cond = C_ALWAYS;
        w.jmp  = S_WAIT;
      end
      S_REJ: begin
        w.act.st_we   = 1'b1;
        w.act.st_val  = ST_CONFLICT;
        w.act.rej_inc = 1'b1;
        w.cond        = C_ALWAYS;
        w.jmp         = S_OUT;
      end
      default: begin
        w.jmp = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mrsr_ram.sv -----
`default_nettype none

module mrsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mrsr_useq.sv -----
`default_nettype none

module mrsr_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mrsr_pkg::flags_t flags_i,
  input  wire logic            in_valid_i,
  input  wire logic            out_busy_i,
  output mrsr_pkg::ctrl_t      ctrl_o
);

  import mrsr_pkg::*;

  step_t  upc_q, upc_d;
  uword_t word;
  logic   taken;

  assign word   = ucode(upc_q);
  assign ctrl_o = word.act;

  always_comb begin
    case (word.cond)
      C_ALWAYS:       taken = 1'b1;
      C_NOT_CLR_LAST: taken = !flags_i.clr_last;
      C_NOT_IN_VALID: taken = !in_valid_i;
      C_INVALID:      taken = flags_i.invalid;
      C_NOT_P_LAST:   taken = !flags_i.p_last;
      C_CLASH:        taken = flags_i.clash;
      C_OUT_BUSY:     taken = out_busy_i;
      default:        taken = 1'b1;
    endcase
    upc_d = taken ? word.jmp : upc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrsr_dpath.sv -----
`default_nettype none

module mrsr_dpath #(
  parameter int DAYS   = mrsr_pkg::DAYS_DEF,
  parameter int PEOPLE = mrsr_pkg::PEOPLE_DEF,
  parameter int SLOTS  = mrsr_pkg::SLOTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mrsr_pkg::ctrl_t                   ctrl_i,
  input  wire logic [mrsr_pkg::DAY_W-1:0]        day_i,
  input  wire logic [mrsr_pkg::SLOT_W-1:0]       start_slot_i,
  input  wire logic [mrsr_pkg::COUNT_W-1:0]      slot_count_i,
  input  wire logic [mrsr_pkg::PART_W-1:0]       participants_i,
  output mrsr_pkg::flags_t                       flags_o,
  output logic      [mrsr_pkg::STATUS_W-1:0]     status_o,
  output logic      [mrsr_pkg::TOTAL_W-1:0]      reject_total_o
);

  import mrsr_pkg::*;

  localparam int ROWS = DAYS * PEOPLE;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NP   = (PEOPLE < PART_W) ? PEOPLE : PART_W;
  localparam int PW   = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW   = DAY_W + $clog2(PEOPLE + 1) + AW;
  localparam int EW   = (($clog2(SLOTS + 1) > COUNT_W) ? $clog2(SLOTS + 1) : COUNT_W) + 1;
  localparam int DW   = (($clog2(DAYS + 1) > DAY_W) ? $clog2(DAYS + 1) : DAY_W) + 1;
  localparam logic [TOTAL_W-1:0] REJ_MAX = '1;

  logic [DAY_W-1:0]    day_q;
  logic [SLOT_W-1:0]   first_q;
  logic [COUNT_W-1:0]  count_q;
  logic [PART_W-1:0]   part_q;
  logic [SLOTS-1:0]    rowbuf_q [NP];
  logic [PW-1:0]       p_q, p_d;
  logic                clash_q, clash_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [TOTAL_W-1:0]  rej_q, rej_d;
  logic [AW-1:0]       clr_q, clr_d;

  logic [EW-1:0]    run_end;
  logic [SLOTS-1:0] mask;
  logic [NP-1:0]    sel;
  logic             p_last;
  logic [CW-1:0]    row_off;
  logic [CW-1:0]    row_addr;
  logic [AW-1:0]    ram_addr;
  logic             ram_we;
  logic             ram_re;
  logic [SLOTS-1:0] ram_wdata;
  logic [SLOTS-1:0] ram_rdata;
  logic             hit;

  assign run_end = EW'(first_q) + EW'(count_q);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      mask[i] = (EW'(i) >= EW'(first_q)) && (EW'(i) < run_end);
    end
  end

  assign sel    = part_q[NP-1:0];
  assign p_last = (p_q == PW'(NP - 1));

  always_comb begin
    if (ctrl_i.rd_first) begin
      row_off = '0;
    end else if (ctrl_i.chk) begin
      row_off = CW'(p_q) + CW'(1);
    end else begin
      row_off = CW'(p_q);
    end
  end

  assign row_addr  = CW'(day_q) * CW'(PEOPLE) + row_off;
  assign ram_addr  = ctrl_i.clr_wr ? clr_q : row_addr[AW-1:0];
  assign ram_re    = ctrl_i.rd_first || (ctrl_i.chk && !p_last);
  assign ram_we    = ctrl_i.clr_wr || (ctrl_i.wr && sel[p_q]);
  assign ram_wdata = ctrl_i.clr_wr ? '0 : (rowbuf_q[p_q] | mask);
  assign hit       = sel[p_q] && ((ram_rdata & mask) != '0);

  mrsr_ram #(
    .WIDTH(SLOTS),
    .DEPTH(ROWS)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    p_d     = p_q;
    clash_d = clash_q;
    st_d    = st_q;
    rej_d   = rej_q;
    clr_d   = clr_q;
    if (ctrl_i.clr_wr) begin
      clr_d = clr_q + AW'(1);
    end
    if (ctrl_i.p_clr) begin
      p_d = '0;
    end else if (ctrl_i.chk || ctrl_i.wr) begin
      p_d = p_last ? '0 : p_q + PW'(1);
    end
    if (ctrl_i.in_rdy) begin
      clash_d = 1'b0;
    end else if (ctrl_i.chk && hit) begin
      clash_d = 1'b1;
    end
    if (ctrl_i.st_we) begin
      st_d = ctrl_i.st_val;
    end
    if (ctrl_i.rej_inc && (rej_q != REJ_MAX)) begin
      rej_d = rej_q + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q     <= '0;
      clash_q <= 1'b0;
      st_q    <= ST_OK;
      rej_q   <= '0;
      clr_q   <= '0;
    end else begin
      p_q     <= p_d;
      clash_q <= clash_d;
      st_q    <= st_d;
      rej_q   <= rej_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_rdy) begin
      day_q   <= day_i;
      first_q <= start_slot_i;
      count_q <= slot_count_i;
      part_q  <= participants_i;
    end
    if (ctrl_i.chk) begin
      rowbuf_q[p_q] <= ram_rdata;
    end
  end

  assign flags_o.clr_last = (clr_q == AW'(ROWS - 1));
  assign flags_o.invalid  = (DW'(day_q) >= DW'(DAYS)) || (run_end > EW'(SLOTS));
  assign flags_o.p_last   = p_last;
  assign flags_o.clash    = clash_q;
  assign status_o         = st_q;
  assign reject_total_o   = rej_q;

endmodule

`default_nettype wire

// ----- rtl/multi_resource_slot_reservation_top.sv -----
// Slot reservation over an occupancy bitmap of DAYS x PEOPLE rows of SLOTS bits.
// A request beat on the input channel carries day, start slot, slot count and a
// participant mask. Each request gives exactly one result beat with a status
// (accepted, conflict, or bad day or run) and the saturating reject count.
// After reset the block clears the occupancy memory one row per cycle;
// in_ready_o stays low until every row has been cleared.
// A request is handled by a microcoded sequencer that reads each participant's
// row once for the conflict check and writes it back once to reserve, so one
// memory port access per person and phase sets the cost. A request out of range
// goes straight to the result load; any other is checked for conflicts over the
// rows and, if accepted, written back to each participant's row. The result
// register is loaded last, and a new request is taken only after the result of
// the last one has been loaded.
// The result sits in an output register; when the receiver stalls, the next
// request is still accepted and processed, and the sequencer waits before
// loading its result until the held beat has been taken.
`default_nettype none

module multi_resource_slot_reservation_top #(
  parameter int DAYS   = mrsr_pkg::DAYS_DEF,
  parameter int PEOPLE = mrsr_pkg::PEOPLE_DEF,
  parameter int SLOTS  = mrsr_pkg::SLOTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [mrsr_pkg::DAY_W-1:0]        day_i,
  input  wire logic [mrsr_pkg::SLOT_W-1:0]       start_slot_i,
  input  wire logic [mrsr_pkg::COUNT_W-1:0]      slot_count_i,
  input  wire logic [mrsr_pkg::PART_W-1:0]       participants_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [mrsr_pkg::STATUS_W-1:0]     status_o,
  output logic      [mrsr_pkg::TOTAL_W-1:0]      reject_total_o
);

  import mrsr_pkg::*;

  ctrl_t               ctrl;
  flags_t              flags;
  logic                out_busy;
  logic [STATUS_W-1:0] dp_status;
  logic [TOTAL_W-1:0]  dp_total;
  logic                out_load;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [TOTAL_W-1:0]  total_q;

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = ctrl.out_ld && !out_busy;

  mrsr_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flags_i   (flags),
    .in_valid_i(in_valid_i),
    .out_busy_i(out_busy),
    .ctrl_o    (ctrl)
  );

  mrsr_dpath #(
    .DAYS  (DAYS),
    .PEOPLE(PEOPLE),
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .day_i         (day_i),
    .start_slot_i  (start_slot_i),
    .slot_count_i  (slot_count_i),
    .participants_i(participants_i),
    .flags_o       (flags),
    .status_o      (dp_status),
    .reject_total_o(dp_total)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= dp_status;
      total_q  <= dp_total;
    end
  end

  assign in_ready_o     = ctrl.in_rdy;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign reject_total_o = total_q;

`ifndef NO_ASSERTIONS
  a_leave_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Sequencer stayed ready after taking a request beat.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_CONFLICT || status_o == ST_RANGE))
    else $error("Result beat carries an unused status code.");

  a_rej_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (dp_total >= $past(dp_total)))
    else $error("Reject count decreased.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |-> !out_load)
    else $error("Result register loaded while a beat was still held.");
`endif

endmodule

`default_nettype wire
